// ===== design/vn_pkg.sv =====
// vn_pkg: shared widths, constants and lane record for vec3_normalize
// no dependencies
package vn_pkg;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned COMP_W    = 32;
  localparam int unsigned SUM_W     = 64;
  localparam int unsigned LEN_W     = 32;
  localparam int unsigned SQ_STEPS  = LEN_W;
  localparam int unsigned SQ_REM_W  = LEN_W + 2;
  localparam int unsigned DIV_STEPS = FRAC_BITS + 1;
  localparam int unsigned QUO_W     = FRAC_BITS + 1;
  localparam int unsigned DIV_REM_W = LEN_W + 1;
  localparam int unsigned LANES     = 3;
  localparam int unsigned LATENCY   = SQ_STEPS + DIV_STEPS + 3;

  typedef struct packed {
    logic              neg;
    logic [COMP_W-1:0] mag;
    logic [COMP_W-1:0] raw;
  } lane_t;
endpackage

// ===== design/vn_sq_lane.sv =====
// vn_sq_lane: one lane, component magnitude and its exact square
// depends on vn_pkg
module vn_sq_lane (
  input  logic                       clk_i,
  input  logic [vn_pkg::COMP_W-1:0]  comp_i,
  output vn_pkg::lane_t              lane_o,
  output logic [vn_pkg::SUM_W-1:0]   sq_o
);
  import vn_pkg::*;

  logic              neg;
  logic [COMP_W-1:0] mag;

  assign neg = comp_i[COMP_W-1];
  assign mag = neg ? (~comp_i + COMP_W'(1)) : comp_i;

  always_ff @(posedge clk_i) begin
    sq_o   <= SUM_W'(mag) * SUM_W'(mag);
    lane_o <= '{neg: neg, mag: mag, raw: comp_i};
  end
endmodule

// ===== design/vn_sqrt.sv =====
// vn_sqrt: pipelined floor square root, one root bit per stage
// depends on vn_pkg
module vn_sqrt (
  input  logic                      clk_i,
  input  logic [vn_pkg::SUM_W-1:0]  rad_i,
  output logic [vn_pkg::LEN_W-1:0]  root_o
);
  import vn_pkg::*;

  logic [SQ_REM_W-1:0] rem_s  [SQ_STEPS+1];
  logic [LEN_W-1:0]    root_s [SQ_STEPS+1];
  logic [SUM_W-1:0]    rad_s  [SQ_STEPS+1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = rad_i;

  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_stage
    logic [SQ_REM_W-1:0] cur;
    logic [SQ_REM_W-1:0] trial;
    logic                fit;

    // bring down the next two radicand bits
    assign cur   = {rem_s[s][SQ_REM_W-3:0], rad_s[s][SUM_W-1 -: 2]};
    assign trial = {root_s[s], 2'b01};
    assign fit   = (cur >= trial);

    always_ff @(posedge clk_i) begin
      rem_s[s+1]  <= fit ? (cur - trial) : cur;
      root_s[s+1] <= {root_s[s][LEN_W-2:0], fit};
      rad_s[s+1]  <= {rad_s[s][SUM_W-3:0], 2'b00};
    end
  end

  assign root_o = root_s[SQ_STEPS];
endmodule

// ===== design/vn_div_lane.sv =====
// vn_div_lane: pipelined restoring divide of (mag << FRAC_BITS) by len
// depends on vn_pkg
module vn_div_lane (
  input  logic                       clk_i,
  input  logic [vn_pkg::COMP_W-1:0]  mag_i,
  input  logic [vn_pkg::LEN_W-1:0]   len_i,
  output logic [vn_pkg::QUO_W-1:0]   quo_o
);
  import vn_pkg::*;

  logic [DIV_REM_W-1:0] rem_s [DIV_STEPS+1];
  logic [LEN_W-1:0]     len_s [DIV_STEPS+1];
  logic [QUO_W-1:0]     quo_s [DIV_STEPS+1];

  // quotient never exceeds 1.0, so the top bits of the dividend start as remainder
  assign rem_s[0] = {2'b00, mag_i[COMP_W-1:1]};
  assign len_s[0] = len_i;
  assign quo_s[0] = '0;

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_stage
    logic [DIV_REM_W-1:0] cur;
    logic [DIV_REM_W-1:0] dvs;
    logic                 fit;
    logic                 bit_in;

    if (j == 0) begin : g_first
      assign bit_in = mag_i[0];
    end else begin : g_rest
      assign bit_in = 1'b0;
    end

    assign cur = {rem_s[j][DIV_REM_W-2:0], bit_in};
    assign dvs = {1'b0, len_s[j]};
    assign fit = (cur >= dvs);

    always_ff @(posedge clk_i) begin
      rem_s[j+1] <= fit ? (cur - dvs) : cur;
      len_s[j+1] <= len_s[j];
      quo_s[j+1] <= {quo_s[j][QUO_W-2:0], fit};
    end
  end

  assign quo_o = quo_s[DIV_STEPS];
endmodule

// ===== design/vec3_normalize.sv =====
// vec3_normalize: fixed-point 3d vector normalization, one vector per cycle
// throughput one beat per cycle, busy is always low, the receiver cannot stall
// depth is set by the 32-stage square root and the FRAC_BITS+1 stage divide lanes
// rst_ni clears only the valid pipe, payload registers are not reset
// depends on vn_pkg, vn_sq_lane, vn_sqrt, vn_div_lane
module vec3_normalize (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [vn_pkg::COMP_W-1:0]  vec_x_i,
  input  logic signed [vn_pkg::COMP_W-1:0]  vec_y_i,
  input  logic signed [vn_pkg::COMP_W-1:0]  vec_z_i,
  output logic                              done_o,
  output logic signed [vn_pkg::COMP_W-1:0]  unit_x_o,
  output logic signed [vn_pkg::COMP_W-1:0]  unit_y_o,
  output logic signed [vn_pkg::COMP_W-1:0]  unit_z_o
);
  import vn_pkg::*;

  // fully pipelined, never holds off a new beat
  assign busy = 1'b0;

  logic [COMP_W-1:0] comp_in [LANES];
  lane_t             lane_a  [LANES];
  logic [SUM_W-1:0]  sq_a    [LANES];

  assign comp_in[0] = vec_x_i;
  assign comp_in[1] = vec_y_i;
  assign comp_in[2] = vec_z_i;

  // stage 1: one squaring lane per component
  for (genvar l = 0; l < LANES; l++) begin : g_sq
    vn_sq_lane u_sq (
      .clk_i  (clk_i),
      .comp_i (comp_in[l]),
      .lane_o (lane_a[l]),
      .sq_o   (sq_a[l])
    );
  end

  // stage 2: merge lanes, sum of squares fits in 64 bits (at most 3 * 2^62)
  logic [SUM_W-1:0] sum_q;
  lane_t            lane_b_q [LANES];

  always_ff @(posedge clk_i) begin
    sum_q <= sq_a[0] + sq_a[1] + sq_a[2];
    for (int l = 0; l < LANES; l++) begin
      lane_b_q[l] <= lane_a[l];
    end
  end

  // square root stages, lane records ride alongside
  logic [LEN_W-1:0] len;
  lane_t            sq_dly_q [SQ_STEPS][LANES];

  vn_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rad_i  (sum_q),
    .root_o (len)
  );

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      sq_dly_q[0][l] <= lane_b_q[l];
      for (int s = 1; s < SQ_STEPS; s++) begin
        sq_dly_q[s][l] <= sq_dly_q[s-1][l];
      end
    end
  end

  // divide stages, one divider lane per component
  logic [QUO_W-1:0] quo        [LANES];
  lane_t            dv_dly_q   [DIV_STEPS][LANES];
  logic             zero_dly_q [DIV_STEPS];

  for (genvar l = 0; l < LANES; l++) begin : g_div
    vn_div_lane u_div (
      .clk_i (clk_i),
      .mag_i (sq_dly_q[SQ_STEPS-1][l].mag),
      .len_i (len),
      .quo_o (quo[l])
    );
  end

  always_ff @(posedge clk_i) begin
    zero_dly_q[0] <= (len == '0);
    for (int s = 1; s < DIV_STEPS; s++) begin
      zero_dly_q[s] <= zero_dly_q[s-1];
    end
    for (int l = 0; l < LANES; l++) begin
      dv_dly_q[0][l] <= sq_dly_q[SQ_STEPS-1][l];
      for (int s = 1; s < DIV_STEPS; s++) begin
        dv_dly_q[s][l] <= dv_dly_q[s-1][l];
      end
    end
  end

  // output stage: restore sign, zero vector passes through
  logic [COMP_W-1:0] unit_d [LANES];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (zero_dly_q[DIV_STEPS-1]) begin
        unit_d[l] = dv_dly_q[DIV_STEPS-1][l].raw;
      end else if (dv_dly_q[DIV_STEPS-1][l].neg) begin
        unit_d[l] = COMP_W'(0) - COMP_W'(quo[l]);
      end else begin
        unit_d[l] = COMP_W'(quo[l]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    unit_x_o <= unit_d[0];
    unit_y_o <= unit_d[1];
    unit_z_o <= unit_d[2];
  end

  // valid pipe tracks each beat through the full depth
  logic [LATENCY-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LATENCY-2:0], start};
    end
  end

  assign done_o = vld_q[LATENCY-1];
endmodule
